>>> rtl/ebs_pkg.sv
// ----------------------------------------------------------------------------
// ebs_pkg: shared types and constants
// State encoding, code point constants and the input item type of the
// backspace span finder.
// ----------------------------------------------------------------------------
package ebs_pkg;

  localparam int unsigned CpW    = 21;
  localparam int unsigned UnitsW = 10;

  typedef enum logic [3:0] {
    ST_START       = 4'd0,
    ST_LF          = 4'd1,
    ST_KEYCAP      = 4'd2,
    ST_VS_KEYCAP   = 4'd3,
    ST_MODIFIER    = 4'd4,
    ST_VS_MODIFIER = 4'd5,
    ST_VS          = 4'd6,
    ST_EMOJI       = 4'd7,
    ST_ZWJ         = 4'd8,
    ST_VS_ZWJ      = 4'd9,
    ST_ODD_RIS     = 4'd10,
    ST_EVEN_RIS    = 4'd11,
    ST_TAG         = 4'd12,
    ST_FINISHED    = 4'd13
  } scan_state_e;

  localparam logic [CpW-1:0] CpRisFirst  = 21'h1F1E6;
  localparam logic [CpW-1:0] CpRisLast   = 21'h1F1FF;
  localparam logic [CpW-1:0] CpKeycap    = 21'h020E3;
  localparam logic [CpW-1:0] CpZwj       = 21'h0200D;
  localparam logic [CpW-1:0] CpCancelTag = 21'hE007F;
  localparam logic [CpW-1:0] CpTagFirst  = 21'hE0020;
  localparam logic [CpW-1:0] CpTagLast   = 21'hE007E;
  localparam logic [CpW-1:0] CpExtBaseA  = 21'h1F91D;
  localparam logic [CpW-1:0] CpExtBaseB  = 21'h1F93C;
  localparam logic [CpW-1:0] CpLf        = 21'h0000A;
  localparam logic [CpW-1:0] CpCr        = 21'h0000D;
  localparam logic [CpW-1:0] CpSuppStart = 21'h10000;
  localparam logic [CpW-1:0] CpDigit0    = 21'h00030;
  localparam logic [CpW-1:0] CpDigit9    = 21'h00039;
  localparam logic [CpW-1:0] CpHash      = 21'h00023;
  localparam logic [CpW-1:0] CpStar      = 21'h0002A;

  typedef struct packed {
    logic [CpW-1:0] code_point;
    logic           begin_search;
    logic           at_text_start;
    logic           prop_emoji;
    logic           prop_emoji_modifier;
    logic           prop_modifier_base;
    logic           prop_variation_selector;
    logic           prop_ccc_zero;
  } item_t;

endpackage

>>> rtl/ebs_item_if.sv
// ----------------------------------------------------------------------------
// ebs_item_if: code point channel
// Valid/ready channel carrying one code point and its property flags.
// ----------------------------------------------------------------------------
interface ebs_item_if import ebs_pkg::*; ();
  logic           valid;
  logic           ready;
  logic [CpW-1:0] code_point;
  logic           begin_search;
  logic           at_text_start;
  logic           prop_emoji;
  logic           prop_emoji_modifier;
  logic           prop_modifier_base;
  logic           prop_variation_selector;
  logic           prop_ccc_zero;

  modport source (
    output valid, code_point, begin_search, at_text_start, prop_emoji,
           prop_emoji_modifier, prop_modifier_base, prop_variation_selector,
           prop_ccc_zero,
    input  ready
  );

  modport sink (
    input  valid, code_point, begin_search, at_text_start, prop_emoji,
           prop_emoji_modifier, prop_modifier_base, prop_variation_selector,
           prop_ccc_zero,
    output ready
  );
endinterface

>>> rtl/ebs_result_if.sv
// ----------------------------------------------------------------------------
// ebs_result_if: delete span channel
// Valid/ready channel carrying the UTF-16 unit count to delete.
// ----------------------------------------------------------------------------
interface ebs_result_if import ebs_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [UnitsW-1:0] delete_units;
  logic              overflowed;

  modport source (
    output valid, delete_units, overflowed,
    input  ready
  );

  modport sink (
    input  valid, delete_units, overflowed,
    output ready
  );
endinterface

>>> rtl/ebs_step.sv
// ----------------------------------------------------------------------------
// ebs_step: backspace state machine step
// Next state, unit count and selector width for one code point, plus the
// flag that a span is complete.
// ----------------------------------------------------------------------------
module ebs_step import ebs_pkg::*; #(
  parameter int unsigned COUNT_MAX = 1023,
  localparam int unsigned CW = $clog2(COUNT_MAX + 1)
) (
  input  item_t           item_i,
  input  scan_state_e     state_i,
  input  logic [CW-1:0]   count_i,
  input  logic [1:0]      sel_units_i,
  input  logic            ovf_i,
  output scan_state_e     state_o,
  output logic [CW-1:0]   count_o,
  output logic [1:0]      sel_units_o,
  output logic            ovf_o,
  output logic            emit_o
);

  localparam int unsigned SW = CW + 3;

  logic [CpW-1:0] cp;
  logic           mod_base;
  logic           is_ris;
  logic           is_kc_base;
  logic           is_tag;
  logic [1:0]     units;
  scan_state_e    cur_st;
  scan_state_e    nxt_st;
  logic [CW-1:0]  base_cnt;
  logic           base_ovf;
  logic [1:0]     base_sel;
  logic           add_en;
  logic [2:0]     add_n;
  logic [SW-1:0]  sum;
  logic           ignore;

  assign cp         = item_i.code_point;
  assign mod_base   = item_i.prop_modifier_base || cp == CpExtBaseA || cp == CpExtBaseB;
  assign is_ris     = cp >= CpRisFirst && cp <= CpRisLast;
  assign is_kc_base = (cp >= CpDigit0 && cp <= CpDigit9) || cp == CpHash || cp == CpStar;
  assign is_tag     = cp >= CpTagFirst && cp <= CpTagLast;
  assign units      = (cp >= CpSuppStart) ? 2'd2 : 2'd1;

  always_comb begin
    ignore   = 1'b0;
    cur_st   = state_i;
    base_cnt = count_i;
    base_ovf = ovf_i;
    base_sel = sel_units_i;
    if (item_i.begin_search) begin
      cur_st   = ST_START;
      base_cnt = '0;
      base_ovf = 1'b0;
      base_sel = 2'd0;
    end else if (state_i == ST_FINISHED) begin
      ignore = 1'b1;
    end

    nxt_st      = ST_FINISHED;
    add_en      = 1'b0;
    add_n       = {1'b0, units};
    count_o     = base_cnt;
    ovf_o       = base_ovf;
    sel_units_o = base_sel;

    case (cur_st)
      ST_START: begin
        count_o = '0;
        ovf_o   = 1'b0;
        add_en  = 1'b1;
        if (cp == CpLf) nxt_st = ST_LF;
        else if (item_i.prop_variation_selector) nxt_st = ST_VS;
        else if (is_ris) nxt_st = ST_ODD_RIS;
        else if (item_i.prop_emoji_modifier) nxt_st = ST_MODIFIER;
        else if (cp == CpKeycap) nxt_st = ST_KEYCAP;
        else if (item_i.prop_emoji) nxt_st = ST_EMOJI;
        else if (cp == CpCancelTag) nxt_st = ST_TAG;
      end
      ST_LF: begin
        add_en = cp == CpCr;
        add_n  = 3'd1;
      end
      ST_ODD_RIS: begin
        if (is_ris) begin
          add_en = 1'b1;
          add_n  = 3'd2;
          nxt_st = ST_EVEN_RIS;
        end
      end
      ST_EVEN_RIS: begin
        if (is_ris) begin
          count_o = (base_cnt >= CW'(2)) ? base_cnt - CW'(2) : '0;
          nxt_st  = ST_ODD_RIS;
        end
      end
      ST_KEYCAP: begin
        if (item_i.prop_variation_selector) begin
          sel_units_o = units;
          nxt_st      = ST_VS_KEYCAP;
        end else begin
          add_en = is_kc_base;
        end
      end
      ST_VS_KEYCAP: begin
        add_en = is_kc_base;
        add_n  = {1'b0, base_sel} + {1'b0, units};
      end
      ST_MODIFIER: begin
        if (item_i.prop_variation_selector) begin
          sel_units_o = units;
          nxt_st      = ST_VS_MODIFIER;
        end else if (mod_base) begin
          add_en = 1'b1;
          nxt_st = ST_EMOJI;
        end
      end
      ST_VS_MODIFIER: begin
        add_en = mod_base;
        add_n  = {1'b0, base_sel} + {1'b0, units};
      end
      ST_VS: begin
        if (item_i.prop_emoji) begin
          add_en = 1'b1;
          nxt_st = ST_EMOJI;
        end else begin
          add_en = !item_i.prop_variation_selector && item_i.prop_ccc_zero;
        end
      end
      ST_EMOJI: begin
        if (cp == CpZwj) nxt_st = ST_ZWJ;
      end
      ST_ZWJ: begin
        if (item_i.prop_emoji) begin
          add_en = 1'b1;
          add_n  = {1'b0, units} + 3'd1;
          nxt_st = item_i.prop_emoji_modifier ? ST_MODIFIER : ST_EMOJI;
        end else if (item_i.prop_variation_selector) begin
          sel_units_o = units;
          nxt_st      = ST_VS_ZWJ;
        end
      end
      ST_VS_ZWJ: begin
        if (item_i.prop_emoji) begin
          add_en      = 1'b1;
          add_n       = {1'b0, base_sel} + {1'b0, units} + 3'd1;
          sel_units_o = 2'd0;
          nxt_st      = ST_EMOJI;
        end
      end
      ST_TAG: begin
        if (is_tag) begin
          add_en = 1'b1;
          add_n  = 3'd2;
          nxt_st = ST_TAG;
        end else if (item_i.prop_emoji) begin
          add_en = 1'b1;
        end else begin
          count_o = CW'(2);
          ovf_o   = 1'b0;
        end
      end
      default: begin
        nxt_st = ST_FINISHED;
      end
    endcase

    sum = {3'b000, count_o} + SW'(add_n);
    if (add_en) begin
      if (sum > SW'(COUNT_MAX)) begin
        count_o = CW'(COUNT_MAX);
        ovf_o   = 1'b1;
      end else begin
        count_o = sum[CW-1:0];
      end
    end

    if (item_i.at_text_start) nxt_st = ST_FINISHED;

    state_o = nxt_st;
    emit_o  = !ignore && nxt_st == ST_FINISHED;
    if (ignore) begin
      state_o     = state_i;
      count_o     = count_i;
      ovf_o       = ovf_i;
      sel_units_o = sel_units_i;
    end
  end

endmodule

>>> rtl/emoji_backspace_span.sv
// ----------------------------------------------------------------------------
// emoji_backspace_span: grapheme-aware backspace span finder
// Input register, state machine step and result register.
// ----------------------------------------------------------------------------
// Code points arrive walking backward from the cursor, one transfer per cycle
// when the result side keeps up. Each item is registered in the input register,
// stepped through the state machine and, if it completes a span, lands in the
// result register. The state register is the only dependency between items,
// so the sustained rate is one code point per cycle; the input stalls only
// while a pending result is not taken and the next item would produce another.
// The count saturates at COUNT_MAX and delete_units shows its low ten bits.
module emoji_backspace_span import ebs_pkg::*; #(
  parameter int unsigned COUNT_MAX = 1023
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  ebs_item_if.sink      item_i,
  ebs_result_if.source  result_o
);

  localparam int unsigned CW = $clog2(COUNT_MAX + 1);

  logic              in_valid_q, in_valid_d;
  item_t             item_q;
  scan_state_e       state_q, state_d;
  logic [CW-1:0]     count_q, count_d;
  logic [1:0]        sel_q, sel_d;
  logic              ovf_q, ovf_d;
  logic              out_valid_q, out_valid_d;
  logic [UnitsW-1:0] units_q;
  logic              out_ovf_q;
  logic              emit;
  logic              out_free;
  logic              advance;
  logic              in_xfer;
  logic [CW+UnitsW-1:0] count_ext;

  ebs_step #(.COUNT_MAX(COUNT_MAX)) u_step (
    .item_i      (item_q),
    .state_i     (state_q),
    .count_i     (count_q),
    .sel_units_i (sel_q),
    .ovf_i       (ovf_q),
    .state_o     (state_d),
    .count_o     (count_d),
    .sel_units_o (sel_d),
    .ovf_o       (ovf_d),
    .emit_o      (emit)
  );

  assign out_free     = !out_valid_q || result_o.ready;
  assign advance      = in_valid_q && (out_free || !emit);
  assign item_i.ready = !in_valid_q || advance;
  assign in_xfer      = item_i.valid && item_i.ready;
  assign count_ext    = {{UnitsW{1'b0}}, count_d};

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_xfer) in_valid_d = 1'b1;
    else if (advance) in_valid_d = 1'b0;
    out_valid_d = out_valid_q;
    if (advance && emit) out_valid_d = 1'b1;
    else if (result_o.ready) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= ST_FINISHED;
      count_q     <= '0;
      sel_q       <= 2'd0;
      ovf_q       <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      if (advance) begin
        state_q <= state_d;
        count_q <= count_d;
        sel_q   <= sel_d;
        ovf_q   <= ovf_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      item_q.code_point              <= item_i.code_point;
      item_q.begin_search            <= item_i.begin_search;
      item_q.at_text_start           <= item_i.at_text_start;
      item_q.prop_emoji              <= item_i.prop_emoji;
      item_q.prop_emoji_modifier     <= item_i.prop_emoji_modifier;
      item_q.prop_modifier_base      <= item_i.prop_modifier_base;
      item_q.prop_variation_selector <= item_i.prop_variation_selector;
      item_q.prop_ccc_zero           <= item_i.prop_ccc_zero;
    end
    if (advance && emit) begin
      units_q   <= count_ext[UnitsW-1:0];
      out_ovf_q <= ovf_d;
    end
  end

  assign result_o.valid        = out_valid_q;
  assign result_o.delete_units = units_q;
  assign result_o.overflowed   = out_ovf_q;

endmodule
